### hw/rtl/vertices_near_line_ring_collect_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex-near-line collector
// Each macro expects signals named clk and arst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef VERTICES_NEAR_LINE_RING_COLLECT_ASSERT_SVH
`define VERTICES_NEAR_LINE_RING_COLLECT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define VNLRC_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence holds in the same cycle as the trigger.
`define VNLRC_IMPLY(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// Consequence holds in the cycle after the trigger.
`define VNLRC_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/vnlrc_pkg.sv
// ----------------------------------------------------------------------------
// vnlrc_pkg
// Types, widths and register codes shared by the collector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vnlrc_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int MUL_W      = 35;
	localparam int HALF_W     = 34;
	localparam int DOT_W      = 2 * HALF_W;
	localparam int WIDE_W     = 2 * DOT_W;
	localparam int RADIUS_W   = 63;
	localparam int CFG_DATA_W = 63;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEG_START_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SEG_END_X   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SEG_END_Y   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SEG_END_Z   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ENTRIES = 3'd7;

	localparam logic [4:0] MAX_ENTRIES_RESET = 5'd16;

	// Sequencer step numbers in the back end.
	localparam logic [4:0] STEP_DOT_END   = 5'd9;
	localparam logic [4:0] STEP_ABS       = 5'd10;
	localparam logic [4:0] STEP_BIG_FIRST = 5'd11;
	localparam logic [4:0] STEP_BIG_END   = 5'd23;
	localparam logic [4:0] STEP_DECIDE    = 5'd24;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic                         last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [3:0]  entry_slot;
		logic [15:0] entry_vertex;
		logic        entry_valid;
		logic [4:0]  found_count;
		logic        index_overflow;
		logic        last_entry;
	} entry_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] seg_start_x;
		logic signed [COORD_BITS-1:0] seg_start_y;
		logic signed [COORD_BITS-1:0] seg_start_z;
		logic signed [COORD_BITS-1:0] seg_end_x;
		logic signed [COORD_BITS-1:0] seg_end_y;
		logic signed [COORD_BITS-1:0] seg_end_z;
		logic [RADIUS_W-1:0]          radius_sq;
		logic [4:0]                   max_entries;
	} cfg_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] w_x;
		logic signed [DIFF_W-1:0] w_y;
		logic signed [DIFF_W-1:0] w_z;
		logic                     over;
		logic                     last;
	} job_t;

endpackage

### hw/rtl/vertices_near_line_ring_collect.sv
// ----------------------------------------------------------------------------
// vertices_near_line_ring_collect
// Collects indices of streamed vertices lying near the line through a segment.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  vertex    start, busy, vertex            taken when start && !busy
//  result    result_strobe, entry           one cycle per transaction, no stall
//  config    wr_en, wr_index, wr_data       written when wr_en, no wait
//
//  In the back end each vertex runs 25 sequencer steps on the single 35x35
//  multiplier (nine dot-product terms, twelve 34-bit partial products of the
//  wide compare), then is placed in the ring, with repeated subtraction when the
//  slot wraps. The last vertex then reports each slot by a registered ring
//  read, then the strobe. The two-entry queue lets the front take up to two
//  vertices ahead. Reset clears control state and restores register
//  defaults; the ring contents are left as they are. The receiver cannot
//  stall results.
//
`timescale 1ns / 1ps

module vertices_near_line_ring_collect #(
	parameter int RING_DEPTH = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  vnlrc_pkg::vertex_t                        vertex,
	output logic                                      result_strobe,
	output vnlrc_pkg::entry_t                         entry,
	input  logic                                      wr_en,
	input  logic [vnlrc_pkg::REG_IDX_W-1:0]           wr_index,
	input  logic [vnlrc_pkg::CFG_DATA_W-1:0]          wr_data
);
	import vnlrc_pkg::*;

	localparam int QW = $bits(job_t) + INDEX_BITS;

	cfg_t                  cfg_q;
	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_not_empty;
	job_t                  f_job;
	logic [INDEX_BITS-1:0] f_idx;
	logic [QW-1:0]         q_rdata;
	job_t                  b_job;
	logic [INDEX_BITS-1:0] b_idx;

	// Hold the configuration registers; write them only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seg_start_x <= '0;
			cfg_q.seg_start_y <= '0;
			cfg_q.seg_start_z <= '0;
			cfg_q.seg_end_x   <= '0;
			cfg_q.seg_end_y   <= '0;
			cfg_q.seg_end_z   <= '0;
			cfg_q.radius_sq   <= '0;
			cfg_q.max_entries <= MAX_ENTRIES_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SEG_START_X: cfg_q.seg_start_x <= wr_data[COORD_BITS-1:0];
				REG_SEG_START_Y: cfg_q.seg_start_y <= wr_data[COORD_BITS-1:0];
				REG_SEG_START_Z: cfg_q.seg_start_z <= wr_data[COORD_BITS-1:0];
				REG_SEG_END_X:   cfg_q.seg_end_x   <= wr_data[COORD_BITS-1:0];
				REG_SEG_END_Y:   cfg_q.seg_end_y   <= wr_data[COORD_BITS-1:0];
				REG_SEG_END_Z:   cfg_q.seg_end_z   <= wr_data[COORD_BITS-1:0];
				REG_RADIUS_SQ:   cfg_q.radius_sq   <= wr_data[RADIUS_W-1:0];
				REG_MAX_ENTRIES: cfg_q.max_entries <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// Front: number the vertex and form its offset from the segment start.
	vnlrc_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.vertex     (vertex),
		.cfg        (cfg_q),
		.queue_full (q_full),
		.busy       (busy),
		.push       (push),
		.job        (f_job),
		.job_idx    (f_idx)
	);

	// Queue: decouple acceptance from the multi-cycle test.
	vnlrc_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     ({f_job, f_idx}),
		.pop       (pop),
		.rdata     (q_rdata),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	assign b_job = q_rdata[QW-1:INDEX_BITS];
	assign b_idx = q_rdata[INDEX_BITS-1:0];

	// Back: run the test, update the ring, report on the last vertex.
	vnlrc_back #(
		.RING_DEPTH(RING_DEPTH),
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (q_not_empty),
		.job           (b_job),
		.job_idx       (b_idx),
		.job_pop       (pop),
		.result_strobe (result_strobe),
		.entry         (entry)
	);

endmodule

### hw/rtl/vnlrc_front.sv
// ----------------------------------------------------------------------------
// vnlrc_front
// Accepts vertices, numbers them and forms the offset from the segment start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vnlrc_front #(
	parameter int INDEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vnlrc_pkg::vertex_t vertex,
	input  vnlrc_pkg::cfg_t    cfg,
	input  logic               queue_full,
	output logic               busy,
	output logic               push,
	output vnlrc_pkg::job_t    job,
	output logic [INDEX_BITS-1:0] job_idx
);
	import vnlrc_pkg::*;

	logic [INDEX_BITS:0] count_q;

	assign busy = queue_full;
	assign push = start && !queue_full;

	assign job.w_x  = DIFF_W'(vertex.pos_x) - DIFF_W'(cfg.seg_start_x);
	assign job.w_y  = DIFF_W'(vertex.pos_y) - DIFF_W'(cfg.seg_start_y);
	assign job.w_z  = DIFF_W'(vertex.pos_z) - DIFF_W'(cfg.seg_start_z);
	assign job.over = count_q[INDEX_BITS];
	assign job.last = vertex.last_vertex;
	assign job_idx  = count_q[INDEX_BITS-1:0];

	// Saturate at 2^INDEX_BITS, restart on the last vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (vertex.last_vertex) begin
				count_q <= '0;
			end else if (!count_q[INDEX_BITS]) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

### hw/rtl/vnlrc_fifo.sv
// ----------------------------------------------------------------------------
// vnlrc_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vnlrc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty,
	output logic             full
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;

	assign rdata     = slot_q[rptr_q];
	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/vnlrc_back.sv
// ----------------------------------------------------------------------------
// vnlrc_back
// Runs the distance test on a shared multiplier, fills the ring and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertices_near_line_ring_collect_assert.svh"

module vnlrc_back #(
	parameter int RING_DEPTH = 16,
	parameter int INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vnlrc_pkg::cfg_t       cfg,
	input  logic                  job_valid,
	input  vnlrc_pkg::job_t       job,
	input  logic [INDEX_BITS-1:0] job_idx,
	output logic                  job_pop,
	output logic                  result_strobe,
	output vnlrc_pkg::entry_t     entry
);
	import vnlrc_pkg::*;

	localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CAP_W  = $clog2(RING_DEPTH + 1);
	localparam logic [CAP_W-1:0] HIT_MAX = CAP_W'(RING_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC   = 3'd1;
	localparam logic [2:0] ST_PLACE  = 3'd2;
	localparam logic [2:0] ST_REDUCE = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;
	localparam logic [2:0] ST_EMPTY  = 3'd7;

	logic [2:0]              state_q;
	logic [4:0]              step_q;
	job_t                    cur_q;
	logic [INDEX_BITS-1:0]   cur_idx_q;

	logic signed [DOT_W-1:0]  ss_q, ww_q, ws_q;
	logic [DOT_W-1:0]         wsabs_q;
	logic signed [WIDE_W-1:0] acc_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_s1;
	logic                      mul_vld_s1;
	logic [4:0]                mul_tag_s1;

	logic [ADDR_W-1:0]     head_q;
	logic [CAP_W-1:0]      hit_q;
	logic                  ovf_q;
	logic                  full_q;
	logic [CAP_W:0]        val_q;
	logic [CAP_W-1:0]      n_q;
	logic [CAP_W-1:0]      k_q;

	logic [INDEX_BITS-1:0] ring_mem [RING_DEPTH];
	logic [INDEX_BITS-1:0] rd_q;

	logic signed [DIFF_W-1:0] d_x, d_y, d_z;
	logic [CAP_W-1:0]         cap;
	logic [3:0]               big_j;
	logic [DOT_W-1:0]         opa, opb;
	logic [HALF_W-1:0]        half_a, half_b;
	logic [WIDE_W-1:0]        term_base, term;
	logic [1:0]               term_sh;
	logic [3:0]               acc_j;
	logic                     match;
	logic                     mem_we;
	logic [CAP_W:0]           val_inc;
	logic [31:0]              vert_wide;

	assign d_x = DIFF_W'(cfg.seg_end_x) - DIFF_W'(cfg.seg_start_x);
	assign d_y = DIFF_W'(cfg.seg_end_y) - DIFF_W'(cfg.seg_start_y);
	assign d_z = DIFF_W'(cfg.seg_end_z) - DIFF_W'(cfg.seg_start_z);

	// Slot count clamped to 1..RING_DEPTH.
	always_comb begin
		if (cfg.max_entries == 5'd0) begin
			cap = CAP_W'(1);
		end else if (32'(cfg.max_entries) > RING_DEPTH) begin
			cap = HIT_MAX;
		end else begin
			cap = CAP_W'(cfg.max_entries);
		end
	end

	// Operand select for the shared multiplier.
	assign big_j = 4'(step_q - STEP_BIG_FIRST);

	always_comb begin
		case (big_j[3:2])
			2'd0:    begin opa = ww_q;    opb = ss_q;    end
			2'd1:    begin opa = wsabs_q; opb = wsabs_q; end
			default: begin opa = DOT_W'(cfg.radius_sq); opb = ss_q; end
		endcase
		half_a = big_j[1] ? opa[DOT_W-1:HALF_W] : opa[HALF_W-1:0];
		half_b = big_j[0] ? opb[DOT_W-1:HALF_W] : opb[HALF_W-1:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (step_q < STEP_DOT_END) begin
			case (step_q)
				5'd0:    begin mul_a = MUL_W'(d_x);       mul_b = MUL_W'(d_x); end
				5'd1:    begin mul_a = MUL_W'(d_y);       mul_b = MUL_W'(d_y); end
				5'd2:    begin mul_a = MUL_W'(d_z);       mul_b = MUL_W'(d_z); end
				5'd3:    begin mul_a = MUL_W'(cur_q.w_x); mul_b = MUL_W'(cur_q.w_x); end
				5'd4:    begin mul_a = MUL_W'(cur_q.w_y); mul_b = MUL_W'(cur_q.w_y); end
				5'd5:    begin mul_a = MUL_W'(cur_q.w_z); mul_b = MUL_W'(cur_q.w_z); end
				5'd6:    begin mul_a = MUL_W'(cur_q.w_x); mul_b = MUL_W'(d_x); end
				5'd7:    begin mul_a = MUL_W'(cur_q.w_y); mul_b = MUL_W'(d_y); end
				default: begin mul_a = MUL_W'(cur_q.w_z); mul_b = MUL_W'(d_z); end
			endcase
		end else begin
			mul_a = $signed({1'b0, half_a});
			mul_b = $signed({1'b0, half_b});
		end
	end

	// Shifted partial product for the wide accumulator.
	assign acc_j     = 4'(mul_tag_s1 - STEP_BIG_FIRST);
	assign term_base = {{(WIDE_W-DOT_W){1'b0}}, prod_s1[DOT_W-1:0]};
	assign term_sh   = {1'b0, acc_j[1]} + {1'b0, acc_j[0]};

	always_comb begin
		case (term_sh)
			2'd0:    term = term_base;
			2'd1:    term = term_base << HALF_W;
			default: term = term_base << (2 * HALF_W);
		endcase
	end

	assign match   = (ss_q != '0) && acc_q[WIDE_W-1];
	assign val_inc = val_q + 1'b1;
	assign mem_we  = (state_q == ST_REDUCE) && (val_q < {1'b0, cap});
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[val_q[ADDR_W-1:0]] <= cur_idx_q;
		end
		if (state_q == ST_READ) begin
			rd_q <= ring_mem[k_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q     <= job;
			cur_idx_q <= job_idx;
		end
	end

	// Datapath accumulators.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			ss_q  <= '0;
			ww_q  <= '0;
			ws_q  <= '0;
			acc_q <= '0;
		end else begin
			if (mul_vld_s1) begin
				if (mul_tag_s1 < 5'd3) begin
					ss_q <= ss_q + $signed(prod_s1[DOT_W-1:0]);
				end else if (mul_tag_s1 < 5'd6) begin
					ww_q <= ww_q + $signed(prod_s1[DOT_W-1:0]);
				end else if (mul_tag_s1 < STEP_DOT_END) begin
					ws_q <= ws_q + $signed(prod_s1[DOT_W-1:0]);
				end else if (acc_j[3:2] == 2'd0) begin
					acc_q <= acc_q + $signed(term);
				end else begin
					acc_q <= acc_q - $signed(term);
				end
			end
			if (state_q == ST_CALC && step_q == STEP_ABS) begin
				wsabs_q <= ws_q[DOT_W-1] ? DOT_W'(-ws_q) : DOT_W'(ws_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1 <= 1'b0;
			mul_tag_s1 <= '0;
		end else begin
			mul_vld_s1 <= (state_q == ST_CALC) && ((step_q < STEP_DOT_END) ||
				((step_q >= STEP_BIG_FIRST) && (step_q < STEP_BIG_END)));
			mul_tag_s1 <= step_q;
		end
	end

	// Sequencer and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			head_q  <= '0;
			hit_q   <= '0;
			ovf_q   <= 1'b0;
			full_q  <= 1'b0;
			val_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					step_q <= step_q + 5'd1;
					if (step_q == STEP_DECIDE) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (cur_q.over) begin
						ovf_q   <= 1'b1;
						state_q <= ST_CHECK;
					end else if (match) begin
						full_q  <= (hit_q >= cap);
						val_q   <= (hit_q >= cap) ? (CAP_W+1)'(head_q) :
							(CAP_W+1)'(head_q) + (CAP_W+1)'(hit_q);
						state_q <= ST_REDUCE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_REDUCE: begin
					// Wrap the slot one subtract per cycle.
					if (val_q >= {1'b0, cap}) begin
						val_q <= val_q - {1'b0, cap};
					end else begin
						if (full_q) begin
							head_q <= (val_inc == {1'b0, cap}) ? '0 :
								val_inc[ADDR_W-1:0];
							hit_q  <= cap;
						end else begin
							hit_q <= hit_q + 1'b1;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (cur_q.last) begin
						n_q <= (hit_q < cap) ? hit_q : cap;
						k_q <= '0;
						state_q <= (hit_q == '0) ? ST_EMPTY : ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (k_q + 1'b1 == n_q) begin
						head_q  <= '0;
						hit_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_EMPTY: begin
					head_q  <= '0;
					hit_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign vert_wide = 32'(rd_q);
	assign result_strobe = (state_q == ST_EMIT) || (state_q == ST_EMPTY);

	always_comb begin
		entry.index_overflow = ovf_q;
		if (state_q == ST_EMIT) begin
			entry.entry_slot   = 4'(k_q);
			entry.entry_vertex = vert_wide[15:0];
			entry.entry_valid  = 1'b1;
			entry.found_count  = 5'(n_q);
			entry.last_entry   = (k_q + 1'b1 == n_q);
		end else begin
			entry.entry_slot   = 4'd0;
			entry.entry_vertex = 16'd0;
			entry.entry_valid  = 1'b0;
			entry.found_count  = 5'd0;
			entry.last_entry   = 1'b1;
		end
	end

	`VNLRC_CHECK(a_hit_bound, hit_q <= HIT_MAX, "stored count exceeds ring depth")
	`VNLRC_NEXT(a_read_then_emit, state_q == ST_READ, state_q == ST_EMIT,
		"ring read not followed by emit")
	`VNLRC_NEXT(a_clear_after_last, result_strobe && entry.last_entry,
		hit_q == '0 && ovf_q == 1'b0, "query state not cleared after last entry")
	`VNLRC_IMPLY(a_emit_in_range, state_q == ST_EMIT, k_q < n_q && n_q <= cap,
		"report slot outside filled range")

endmodule

### tb/vertices_near_line_ring_collect_tb.sv
// ----------------------------------------------------------------------------
// vertices_near_line_ring_collect_tb
// Streams vertex transactions into the near-line collector and checks every
// reported ring entry against a cycle-free predictor of the block kept in the
// bench. A short table of directed transactions comes first, then randomized
// queries built mostly from points scattered around the configured line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertices_near_line_ring_collect_tb;
	import vnlrc_pkg::*;

	localparam int RING_SLOTS   = 16;
	localparam int INDEX_LIMIT  = 65536;
	// Worst-case drain time: two queued vertices plus a full report.
	localparam int SETTLE_CYCLES = 160;

	// Setup applied before a directed row (after the block has gone idle).
	typedef enum int {SETUP_NONE, SETUP_LINE, SETUP_MAX_ZERO, SETUP_MAX_HIGH,
		SETUP_RADIUS_MAX, SETUP_MAX_SHRINK} setup_e;

	typedef struct {
		setup_e  setup;
		vertex_t v;
		bit      typed;
		entry_t  want;
	} vrow_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	vertex_t              vertex;
	logic                 result_strobe;
	entry_t               entry;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	vertices_near_line_ring_collect u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.vertex       (vertex),
		.result_strobe(result_strobe),
		.entry        (entry),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the registers and the ring.
	// ------------------------------------------------------------------
	logic signed [31:0] seg_lo [3];
	logic signed [31:0] seg_hi [3];
	logic [62:0]        radius_q;
	logic [4:0]         slot_limit;
	logic [15:0]        ring_idx [RING_SLOTS];
	int unsigned        head_slot;
	int unsigned        stored_hits;
	int unsigned        next_index;
	bit                 index_ovf;

	entry_t pending_entries[$];
	int     mismatch_count;
	int     gap_max;

	// Slots not written in the current query hold unknowns: their content is
	// undefined, so the monitor skips the vertex field for them.
	function automatic void clear_query();
		for (int i = 0; i < RING_SLOTS; i++) begin
			ring_idx[i] = 'x;
		end
		head_slot   = 0;
		stored_hits = 0;
		next_index  = 0;
		index_ovf   = 1'b0;
	endfunction

	// Exact perpendicular-distance test, division free, on wide signed integers.
	function automatic bit near_line(vertex_t v);
		logic signed [199:0] sx, sy, sz, dx, dy, dz, wx, wy, wz;
		logic signed [199:0] ss, ww, ws, lhs, rhs, rr;
		sx = seg_lo[0];
		sy = seg_lo[1];
		sz = seg_lo[2];
		dx = seg_hi[0];
		dy = seg_hi[1];
		dz = seg_hi[2];
		dx = dx - sx;
		dy = dy - sy;
		dz = dz - sz;
		wx = v.pos_x;
		wy = v.pos_y;
		wz = v.pos_z;
		wx = wx - sx;
		wy = wy - sy;
		wz = wz - sz;
		ss = dx * dx + dy * dy + dz * dz;
		if (ss == 0) begin
			return 1'b0;
		end
		ww  = wx * wx + wy * wy + wz * wz;
		ws  = wx * dx + wy * dy + wz * dz;
		rr  = {137'b0, radius_q};
		lhs = ww * ss - ws * ws;
		rhs = rr * ss;
		return lhs < rhs;
	endfunction

	// Advance the predictor by one accepted vertex; queue what it reports.
	function automatic void predict_entries(vertex_t v);
		int unsigned cap;
		int unsigned n;
		int unsigned slot;
		entry_t      e;
		cap = (slot_limit == 0) ? 1 : (slot_limit > RING_SLOTS) ? RING_SLOTS : slot_limit;
		if (near_line(v)) begin
			if (next_index >= INDEX_LIMIT) begin
				index_ovf = 1'b1;
			end else if (stored_hits >= cap) begin
				slot = head_slot % cap;
				ring_idx[slot] = next_index[15:0];
				head_slot = (slot + 1) % cap;
				stored_hits = cap;
			end else begin
				slot = (head_slot + stored_hits) % cap;
				ring_idx[slot] = next_index[15:0];
				stored_hits++;
			end
		end else if (next_index >= INDEX_LIMIT) begin
			index_ovf = 1'b1;
		end
		if (next_index < INDEX_LIMIT) begin
			next_index++;
		end
		if (!v.last_vertex) begin
			return;
		end
		n = (stored_hits < cap) ? stored_hits : cap;
		if (n == 0) begin
			e = '0;
			e.index_overflow = index_ovf;
			e.last_entry     = 1'b1;
			pending_entries.push_back(e);
		end
		for (int k = 0; k < n; k++) begin
			e.entry_slot     = k[3:0];
			e.entry_vertex   = ring_idx[k];
			e.entry_valid    = 1'b1;
			e.found_count    = n[4:0];
			e.index_overflow = index_ovf;
			e.last_entry     = (k + 1 == n);
			pending_entries.push_back(e);
		end
		clear_query();
	endfunction

	// ------------------------------------------------------------------
	// Result monitor: sample at the falling edge, away from the driving edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		entry_t want;
		if (arst_n && result_strobe) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected entry transaction: %p", entry);
				mismatch_count++;
			end else begin
				want = pending_entries.pop_front();
				if (entry.entry_slot !== want.entry_slot) begin
					$error("entry_slot: expected %0d, actual %0d", want.entry_slot,
						entry.entry_slot);
					mismatch_count++;
				end
				if (!$isunknown(want.entry_vertex) &&
						(entry.entry_vertex !== want.entry_vertex)) begin
					$error("entry_vertex: expected %0d, actual %0d", want.entry_vertex,
						entry.entry_vertex);
					mismatch_count++;
				end
				if (entry.entry_valid !== want.entry_valid) begin
					$error("entry_valid: expected %0d, actual %0d", want.entry_valid,
						entry.entry_valid);
					mismatch_count++;
				end
				if (entry.found_count !== want.found_count) begin
					$error("found_count: expected %0d, actual %0d", want.found_count,
						entry.found_count);
					mismatch_count++;
				end
				if (entry.index_overflow !== want.index_overflow) begin
					$error("index_overflow: expected %0d, actual %0d", want.index_overflow,
						entry.index_overflow);
					mismatch_count++;
				end
				if (entry.last_entry !== want.last_entry) begin
					$error("last_entry: expected %0d, actual %0d", want.last_entry,
						entry.last_entry);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Write one register; the caller makes sure the block is idle.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en    <= 1'b0;
		case (idx)
			REG_SEG_START_X: seg_lo[0] = data[31:0];
			REG_SEG_START_Y: seg_lo[1] = data[31:0];
			REG_SEG_START_Z: seg_lo[2] = data[31:0];
			REG_SEG_END_X:   seg_hi[0] = data[31:0];
			REG_SEG_END_Y:   seg_hi[1] = data[31:0];
			REG_SEG_END_Z:   seg_hi[2] = data[31:0];
			REG_RADIUS_SQ:   radius_q  = data[62:0];
			REG_MAX_ENTRIES: slot_limit = data[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Wait for every expected entry, then for the back end to empty out.
	task automatic drain();
		start <= 1'b0;
		wait (pending_entries.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_segment(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz, logic signed [31:0] ex, logic signed [31:0] ey,
			logic signed [31:0] ez);
		write_reg(REG_SEG_START_X, {{31{sx[31]}}, sx});
		write_reg(REG_SEG_START_Y, {{31{sy[31]}}, sy});
		write_reg(REG_SEG_START_Z, {{31{sz[31]}}, sz});
		write_reg(REG_SEG_END_X,   {{31{ex[31]}}, ex});
		write_reg(REG_SEG_END_Y,   {{31{ey[31]}}, ey});
		write_reg(REG_SEG_END_Z,   {{31{ez[31]}}, ez});
	endtask

	// Offer one vertex transaction, holding start high until it is taken.
	// With typed set, the typed entry replaces the predictor's report.
	task automatic send_vertex(vertex_t v, bit typed = 1'b0, entry_t want = '0);
		int  gap;
		bit  taken;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		vertex <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		if (typed) begin
			predict_entries(v);
			pending_entries.delete(pending_entries.size() - 1);
			pending_entries.push_back(want);
		end else begin
			predict_entries(v);
		end
	endtask

	function automatic vertex_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit last);
		vertex_t v;
		v.pos_x = x;
		v.pos_y = y;
		v.pos_z = z;
		v.last_vertex = last;
		return v;
	endfunction

	function automatic vrow_t mk_row(setup_e s, vertex_t v, bit typed = 1'b0,
			entry_t want = '0);
		vrow_t r;
		r.setup = s;
		r.v     = v;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	task automatic apply_setup(setup_e s);
		if (s == SETUP_NONE) begin
			return;
		end
		drain();
		case (s)
			SETUP_LINE: begin
				// Unit segment along x, radius 1.0, full ring.
				write_segment(32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0);
				write_reg(REG_RADIUS_SQ, 63'h1_0000_0000);
				write_reg(REG_MAX_ENTRIES, 63'd16);
			end
			SETUP_MAX_ZERO:   write_reg(REG_MAX_ENTRIES, 63'd0);
			SETUP_MAX_HIGH:   write_reg(REG_MAX_ENTRIES, 63'd31);
			SETUP_RADIUS_MAX: write_reg(REG_RADIUS_SQ, {63{1'b1}});
			SETUP_MAX_SHRINK: write_reg(REG_MAX_ENTRIES, 63'd2);
			default: ;
		endcase
	endtask

	// Random point near the line: start + k*dir + noise, wrapping in 32 bits.
	function automatic vertex_t near_point(int noise_bits, bit last);
		int k;
		logic [31:0] p [3];
		k = $urandom_range(0, 8) - 4;
		for (int a = 0; a < 3; a++) begin
			p[a] = seg_lo[a] + k * (seg_hi[a] - seg_lo[a])
				+ ($urandom & ((32'd1 << noise_bits) - 1)) - (32'd1 << (noise_bits - 1));
		end
		return mk_vertex(p[0], p[1], p[2], last);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		vrow_t  rows[$];
		entry_t typed_want;
		int     items_sent;
		int     noise_bits;
		int     qlen;
		int     span;
		logic [31:0] c [6];

		arst_n   <= 1'b0;
		start    <= 1'b0;
		vertex   <= '0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		mismatch_count = 0;
		gap_max = 0;
		for (int a = 0; a < 3; a++) begin
			seg_lo[a] = '0;
			seg_hi[a] = '0;
		end
		radius_q   = '0;
		slot_limit = MAX_ENTRIES_RESET;
		clear_query();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. After reset the segment has zero length: nothing matches.
		typed_want = '0;
		typed_want.last_entry = 1'b1;
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h7fffffff, 32'h80000000, 32'h0, 1'b1),
			1'b1, typed_want));
		rows.push_back(mk_row(SETUP_LINE, mk_vertex(32'h0, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h7fffffff, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h80000000, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE,
			mk_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE,
			mk_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h0, 32'hffff, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h0, 32'h10000, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h0, 32'h0, 32'hffff0001, 1'b1)));
		// Slot count of zero acts as one: only the newest of three hits survives.
		typed_want = '{entry_slot: 4'd0, entry_vertex: 16'd2, entry_valid: 1'b1,
			found_count: 5'd1, index_overflow: 1'b0, last_entry: 1'b1};
		rows.push_back(mk_row(SETUP_MAX_ZERO, mk_vertex(32'h100, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h200, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h300, 32'h0, 32'h0, 1'b1),
			1'b1, typed_want));
		// Slot count above the ring depth acts as the full ring.
		rows.push_back(mk_row(SETUP_MAX_HIGH, mk_vertex(32'h0, 32'h0, 32'h0, 1'b0)));
		for (int i = 0; i < 17; i++) begin
			rows.push_back(mk_row(SETUP_NONE, mk_vertex(i << 12, 32'h0, 32'h0, 1'b0)));
		end
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h5, 32'h0, 32'h0, 1'b1)));
		// Largest radius, then shrink the ring with hits already stored.
		rows.push_back(mk_row(SETUP_RADIUS_MAX,
			mk_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0)));
		for (int i = 0; i < 4; i++) begin
			rows.push_back(mk_row(SETUP_NONE, mk_vertex(i, i, i, 1'b0)));
		end
		rows.push_back(mk_row(SETUP_MAX_SHRINK, mk_vertex(32'h1, 32'h0, 32'h0, 1'b0)));
		rows.push_back(mk_row(SETUP_NONE, mk_vertex(32'h2, 32'h0, 32'h0, 1'b1)));

		foreach (rows[i]) begin
			apply_setup(rows[i].setup);
			send_vertex(rows[i].v, rows[i].typed, rows[i].want);
		end

		// Randomized phases: each draws a fresh segment, radius and slot count.
		items_sent = 0;
		while (items_sent < 192) begin
			drain();
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
			span = $urandom_range(4, 24);
			for (int a = 0; a < 6; a++) begin
				if ($urandom_range(0, 5) == 0) begin
					c[a] = $urandom;
				end else begin
					c[a] = $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
				end
			end
			// Now and then a zero-length segment.
			if ($urandom_range(0, 9) == 0) begin
				c[3] = c[0];
				c[4] = c[1];
				c[5] = c[2];
			end
			write_segment(c[0], c[1], c[2], c[3], c[4], c[5]);
			noise_bits = $urandom_range(2, 24);
			if ($urandom_range(0, 9) == 0) begin
				write_reg(REG_RADIUS_SQ, CFG_DATA_W'({$urandom, $urandom}));
			end else begin
				write_reg(REG_RADIUS_SQ, 63'd1 << (2 * noise_bits - 2));
			end
			write_reg(REG_MAX_ENTRIES, CFG_DATA_W'($urandom_range(0, 31)));
			for (int q = 0; (q < 3) && (items_sent < 192); q++) begin
				qlen = $urandom_range(1, 30);
				for (int i = 0; (i < qlen) && (items_sent < 192); i++) begin
					// Leave some queries open so the next phase reconfigures mid-query.
					bit last;
					last = (i == qlen - 1) && ($urandom_range(0, 7) != 0);
					if ($urandom_range(0, 3) == 0) begin
						send_vertex(mk_vertex($urandom, $urandom, $urandom, last));
					end else begin
						send_vertex(near_point(noise_bits, last));
					end
					items_sent++;
				end
			end
		end

		drain();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vnlrc_pkg.sv
hw/rtl/vnlrc_front.sv
hw/rtl/vnlrc_fifo.sv
hw/rtl/vnlrc_back.sv
hw/rtl/vertices_near_line_ring_collect.sv
tb/vertices_near_line_ring_collect_tb.sv
